// ----- hdl/blp_pkg.sv -----
// shared types, constants and elaboration-time tables for the blinn-phong lobe pipeline
// no dependencies
package blp_pkg;

    localparam int LOG_FRAC = 24;
    localparam int QUO_W    = 33;
    localparam int NEGL_W   = 30;
    localparam int E_W      = 46;
    localparam int P_W      = 33;

    localparam logic [29:0] INV_TWO_PI = 30'd683565276;
    localparam logic [29:0] LOBE_MAX   = 30'h3FFF_FFFF;

    typedef struct packed {
        logic below;
        logic zero;
    } t_side;

    typedef logic [LOG_FRAC-1:0][31:0] t_root_tab;

    // integer square root, used only while building the constant table
    function automatic logic [63:0] f_isqrt(input logic [63:0] x);
        logic [63:0] xv;
        logic [63:0] r;
        logic [63:0] b;
        xv = x;
        r  = '0;
        b  = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (b > xv) begin
                b = b >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (b != '0) begin
                if (xv >= r + b) begin
                    xv = xv - (r + b);
                    r  = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // successive roots of one half in q0.32: entry i is 2^-(2^-(i+1))
    function automatic t_root_tab f_root_tab();
        t_root_tab   tab;
        logic [63:0] c;
        c      = f_isqrt(64'h8000_0000_0000_0000);
        tab[0] = c[31:0];
        for (int i = 1; i < LOG_FRAC; i++) begin
            c      = f_isqrt({c[31:0], 32'd0});
            tab[i] = c[31:0];
        end
        return tab;
    endfunction

endpackage

// ----- hdl/blp_div.sv -----
// pipelined restoring divider, one quotient bit per stage: floor(num * 2^32 / den)
// depends on blp_pkg
module blp_div import blp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_side            i_side,
    input  logic [31:0]      i_num,
    input  logic [33:0]      i_den,
    output logic             o_vld,
    output t_side            o_side,
    output logic [QUO_W-1:0] o_quo
);

    logic [33:0]      r_rem  [QUO_W];
    logic [33:0]      r_den  [QUO_W];
    logic [QUO_W-1:0] r_quo  [QUO_W];
    t_side            r_side [QUO_W];
    logic [QUO_W-1:0] r_vld;

    logic [34:0]      w_cand [QUO_W];
    logic [34:0]      w_diff [QUO_W];
    logic [33:0]      w_den  [QUO_W];
    logic [QUO_W-1:0] w_bit;
    logic [33:0]      n_rem  [QUO_W];
    logic [QUO_W-1:0] n_quo  [QUO_W];

    always_comb begin
        // top quotient bit straight from the numerator
        w_cand[0] = {3'b000, i_num};
        w_den[0]  = i_den;
        w_diff[0] = w_cand[0] - {1'b0, w_den[0]};
        w_bit[0]  = (w_cand[0] >= {1'b0, w_den[0]});
        n_rem[0]  = w_bit[0] ? w_diff[0][33:0] : w_cand[0][33:0];
        n_quo[0]  = {{(QUO_W-1){1'b0}}, w_bit[0]};
        for (int j = 1; j < QUO_W; j++) begin
            w_cand[j] = {r_rem[j-1], 1'b0};
            w_den[j]  = r_den[j-1];
            w_diff[j] = w_cand[j] - {1'b0, w_den[j]};
            w_bit[j]  = (w_cand[j] >= {1'b0, w_den[j]});
            n_rem[j]  = w_bit[j] ? w_diff[j][33:0] : w_cand[j][33:0];
            n_quo[j]  = {r_quo[j-1][QUO_W-2:0], w_bit[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QUO_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int j = 0; j < QUO_W; j++) begin
                r_rem[j] <= n_rem[j];
                r_den[j] <= w_den[j];
                r_quo[j] <= n_quo[j];
            end
            for (int j = 1; j < QUO_W; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    assign o_vld  = r_vld[QUO_W-1];
    assign o_side = r_side[QUO_W-1];
    assign o_quo  = r_quo[QUO_W-1];

endmodule

// ----- hdl/blp_log.sv -----
// pipelined -log2 of a q1.32 cosine squared, one squaring per stage
// depends on blp_pkg
module blp_log import blp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  t_side             i_side,
    input  logic [QUO_W-1:0]  i_c2,
    output logic              o_vld,
    output t_side             o_side,
    output logic [NEGL_W-1:0] o_negl
);

    localparam int NST = LOG_FRAC + 1;

    logic [30:0]          r_m    [NST];
    logic [5:0]           r_k    [NST];
    logic [LOG_FRAC-1:0]  r_frac [NST];
    t_side                r_side [NST+1];
    logic [NST:0]         r_vld;
    logic [NEGL_W-1:0]    r_negl;

    logic [5:0]           w_k;
    logic [QUO_W-1:0]     w_sh;
    logic [61:0]          w_sq   [NST];
    logic [30:0]          n_m    [NST];
    logic [LOG_FRAC-1:0]  n_frac [NST];
    logic [LOG_FRAC-1:0]  w_bit;

    // leading one and normalize into q1.30
    always_comb begin
        w_k = '0;
        for (int b = 0; b < QUO_W; b++) begin
            if (i_c2[b]) begin
                w_k = 6'(b);
            end
        end
        if (w_k >= 6'd30) begin
            w_sh = i_c2 >> (w_k - 6'd30);
        end else begin
            w_sh = i_c2 << (6'd30 - w_k);
        end
    end

    always_comb begin
        w_sq[0]   = '0;
        n_m[0]    = w_sh[30:0];
        n_frac[0] = '0;
        for (int s = 1; s < NST; s++) begin
            w_sq[s]     = r_m[s-1] * r_m[s-1];
            w_bit[s-1]  = w_sq[s][61];
            n_m[s]      = w_bit[s-1] ? w_sq[s][61:31] : w_sq[s][60:30];
            n_frac[s]   = {r_frac[s-1][LOG_FRAC-2:0], w_bit[s-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k[0]    <= w_k;
            r_side[0] <= i_side;
            for (int s = 0; s < NST; s++) begin
                r_m[s]    <= n_m[s];
                r_frac[s] <= n_frac[s];
            end
            for (int s = 1; s < NST; s++) begin
                r_k[s] <= r_k[s-1];
            end
            for (int s = 1; s <= NST; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_negl <= {6'd32 - r_k[NST-1], 24'd0} - {6'd0, r_frac[NST-1]};
        end
    end

    assign o_vld  = r_vld[NST];
    assign o_side = r_side[NST];
    assign o_negl = r_negl;

endmodule

// ----- hdl/blp_pow.sv -----
// pipelined 2^-e in q1.32: one root-of-one-half multiply per fraction bit, then the integer shift
// depends on blp_pkg
module blp_pow import blp_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  t_side          i_side,
    input  logic [E_W-1:0] i_e,
    output logic           o_vld,
    output t_side          o_side,
    output logic [P_W-1:0] o_p
);

    localparam t_root_tab ROOTS = f_root_tab();

    logic [P_W-1:0]      r_p    [LOG_FRAC];
    logic [E_W-1:0]      r_e    [LOG_FRAC];
    t_side               r_side [LOG_FRAC+1];
    logic [LOG_FRAC:0]   r_vld;
    logic [P_W-1:0]      r_pout;

    logic [P_W-1:0]      w_pin  [LOG_FRAC];
    logic [E_W-1:0]      w_ein  [LOG_FRAC];
    logic [64:0]         w_prod [LOG_FRAC];
    logic [P_W-1:0]      n_p    [LOG_FRAC];
    logic [21:0]         w_ip;

    always_comb begin
        w_pin[0] = {1'b1, 32'd0};
        w_ein[0] = i_e;
        for (int s = 1; s < LOG_FRAC; s++) begin
            w_pin[s] = r_p[s-1];
            w_ein[s] = r_e[s-1];
        end
        for (int s = 0; s < LOG_FRAC; s++) begin
            w_prod[s] = w_pin[s] * ROOTS[s];
            n_p[s]    = w_ein[s][LOG_FRAC-1-s] ? w_prod[s][64:32] : w_pin[s];
        end
        w_ip = r_e[LOG_FRAC-1][E_W-1:LOG_FRAC];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LOG_FRAC-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 0; s < LOG_FRAC; s++) begin
                r_p[s] <= n_p[s];
                r_e[s] <= w_ein[s];
            end
            for (int s = 1; s <= LOG_FRAC; s++) begin
                r_side[s] <= r_side[s-1];
            end
            if (w_ip >= 22'd33) begin
                r_pout <= '0;
            end else begin
                r_pout <= r_p[LOG_FRAC-1] >> w_ip;
            end
        end
    end

    assign o_vld  = r_vld[LOG_FRAC];
    assign o_side = r_side[LOG_FRAC];
    assign o_p    = r_pout;

endmodule

// ----- hdl/blinn_phong_lobe_eval.sv -----
// top level of the normalized blinn-phong lobe pipeline
// depends on blp_pkg, blp_div, blp_log, blp_pow
//
// One item per clock while the output buffer is not full: every item passes a 90-stage
// pipeline (3 front stages for the half vector and its squared length, 33 divider stages
// for cos^2, 26 log stages, the exponent multiply, 25 pow stages, 2 scaling stages), and
// its result is then written into the output buffer and shown on the result channel.
// Depth is set by the one-bit-per-stage divider and the 24 squaring and 24 root-multiply
// stages. A two-entry output buffer sits behind the pipeline; the whole pipeline holds
// while that buffer is full, and ready depends only on its fill count. The shininess
// register may be written only while the block is idle.
module blinn_phong_lobe_eval import blp_pkg::*; #(
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [24:0]        i_cfg_wdata,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_in_x,
    input  logic signed [15:0] i_in_y,
    input  logic signed [15:0] i_in_z,
    input  logic signed [15:0] i_out_x,
    input  logic signed [15:0] i_out_y,
    input  logic signed [15:0] i_out_z,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [29:0]        o_lobe_value,
    output logic               o_below_horizon
);

    localparam int SCALE_SHIFT = 40 - OUT_FRAC_BITS;

    // shininess register, q17.8
    logic [24:0] r_shininess;

    // pipeline advance, common to every stage
    logic en;

    // front stages: half vector, squares, length and numerator
    logic               r_v1, r_v2, r_v3;
    logic signed [16:0] r_hx, r_hy, r_hz;
    logic signed [33:0] w_sqx, w_sqy, w_sqz;
    logic [32:0]        r_sqx, r_sqy, r_sqz;
    logic               r_below2, r_below3;
    logic [33:0]        r_len;
    logic [31:0]        r_num;
    t_side              w_div_side_in;

    // divider, log, pow
    logic               w_div_vld, w_log_vld, w_pow_vld;
    t_side              w_div_side, w_log_side_in, w_log_side, w_pow_side;
    logic [QUO_W-1:0]   w_quo;
    logic [NEGL_W-1:0]  w_negl;
    logic [P_W-1:0]     w_pow_p;

    // exponent stage
    logic               r_ve;
    t_side              r_side_e;
    logic [54:0]        w_eprod;
    logic [E_W-1:0]     r_e;

    // scaling stages
    logic               r_vp, r_vm;
    logic               r_below_p, r_below_m;
    logic [P_W-1:0]     w_pf;
    logic [25:0]        w_n2;
    logic [58:0]        r_prod;
    logic [58:0]        w_a;
    logic [61:0]        r_lop;
    logic [56:0]        r_hip;
    logic [57:0]        w_sum;
    logic [29:0]        w_val;

    // output buffer
    logic [29:0]        r_buf_val [2];
    logic [1:0]         r_buf_bh;
    logic               r_wp, r_rp;
    logic [1:0]         r_cnt;
    logic               w_push, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shininess <= 25'd1280;
        end else if (i_cfg_we) begin
            r_shininess <= i_cfg_wdata;
        end
    end

    assign en         = (r_cnt != 2'd2);
    assign o_in_ready = en;

    // valid bits of the stages that live here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ve <= 1'b0;
            r_vp <= 1'b0;
            r_vm <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ve <= w_log_vld;
            r_vp <= w_pow_vld;
            r_vm <= r_vp;
        end
    end

    assign w_sqx = r_hx * r_hx;
    assign w_sqy = r_hy * r_hy;
    assign w_sqz = r_hz * r_hz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // half vector h = u + v
            r_hx <= {i_in_x[15], i_in_x} + {i_out_x[15], i_out_x};
            r_hy <= {i_in_y[15], i_in_y} + {i_out_y[15], i_out_y};
            r_hz <= {i_in_z[15], i_in_z} + {i_out_z[15], i_out_z};
            // squares; cosine not positive when hz <= 0
            r_sqx    <= w_sqx[32:0];
            r_sqy    <= w_sqy[32:0];
            r_sqz    <= w_sqz[32:0];
            r_below2 <= r_hz[16] || (r_hz == '0);
            // squared length and hz^2
            r_len    <= {1'b0, r_sqx} + {1'b0, r_sqy} + {1'b0, r_sqz};
            r_num    <= r_sqz[31:0];
            r_below3 <= r_below2;
        end
    end

    assign w_div_side_in = '{below: r_below3, zero: 1'b0};

    // cos^2 = hz^2 * 2^32 / |h|^2
    blp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v3),
        .i_side  (w_div_side_in),
        .i_num   (r_num),
        .i_den   (r_len),
        .o_vld   (w_div_vld),
        .o_side  (w_div_side),
        .o_quo   (w_quo)
    );

    // cos^2 truncated to zero takes the special path at the end
    assign w_log_side_in = '{below: w_div_side.below, zero: (w_quo == '0)};

    blp_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (w_div_vld),
        .i_side  (w_log_side_in),
        .i_c2    (w_quo),
        .o_vld   (w_log_vld),
        .o_side  (w_log_side),
        .o_negl  (w_negl)
    );

    // -log2(cos^n) in q.24
    assign w_eprod = w_negl * r_shininess;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e      <= w_eprod[54:9];
            r_side_e <= w_log_side;
        end
    end

    blp_pow u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_ve),
        .i_side  (r_side_e),
        .i_e     (r_e),
        .o_vld   (w_pow_vld),
        .o_side  (w_pow_side),
        .o_p     (w_pow_p)
    );

    // cos^2 of zero: 0^n, which is one only for n of zero
    always_comb begin
        if (w_pow_side.zero) begin
            w_pf = (r_shininess == '0) ? {1'b1, 32'd0} : '0;
        end else begin
            w_pf = w_pow_p;
        end
        w_n2 = {1'b0, r_shininess} + 26'd512;
    end

    assign w_a = r_prod >> SCALE_SHIFT;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // cos^n * (n + 2)
            r_prod    <= w_pf * w_n2;
            r_below_p <= w_pow_side.below;
            // times 1/(2*pi), split at bit 32 to keep the multipliers narrow
            r_lop     <= w_a[31:0] * INV_TWO_PI;
            r_hip     <= w_a[58:32] * INV_TWO_PI;
            r_below_m <= r_below_p;
        end
    end

    // final sum and saturation
    always_comb begin
        w_sum = {1'b0, r_hip} + {28'd0, r_lop[61:32]};
        if (r_below_m) begin
            w_val = '0;
        end else if (w_sum > {28'd0, LOBE_MAX}) begin
            w_val = LOBE_MAX;
        end else begin
            w_val = w_sum[29:0];
        end
    end

    // two-entry output buffer
    assign w_push = en && r_vm;
    assign w_pop  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf_val[r_wp] <= w_val;
            r_buf_bh[r_wp]  <= r_below_m;
        end
    end

    assign o_out_valid     = (r_cnt != 2'd0);
    assign o_lobe_value    = r_buf_val[r_rp];
    assign o_below_horizon = r_buf_bh[r_rp];

    // buffer never overfills
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3))
        else $error("output buffer count out of range");

    // a below-horizon result always carries a zero value
    a_below_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_below_horizon) |-> (o_lobe_value == '0))
        else $error("below-horizon result with nonzero value");

    // while the buffer is full the last stage holds its item
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r_vm) |=> (r_vm && $stable(r_lop) && $stable(r_hip)))
        else $error("pipeline moved during a hold");

endmodule

// ----- verif/blinn_phong_lobe_eval_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for blinn_phong_lobe_eval: directed table plus random vectors
// over several shininess settings, checked against an in-bench fixed-point lobe predictor
// depends on blp_pkg and the blinn_phong_lobe_eval rtl
module blinn_phong_lobe_eval_tb;
    import blp_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int DRAIN_CYC   = 110;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 170;        // per shininess phase
    localparam int N_PHASES    = 6;
    localparam int HOLD_CYC    = 400;

    // idle profiles, cycled through the phases
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [29:0] lobe;
        logic        below;
    } t_lobe_res;

    typedef struct {
        logic signed [15:0] ix, iy, iz, ox, oy, oz;
        bit                 typed;     // expected result typed in below
        t_lobe_res          res;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [24:0]        i_cfg_wdata = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [15:0] i_in_x = '0, i_in_y = '0, i_in_z = '0;
    logic signed [15:0] i_out_x = '0, i_out_y = '0, i_out_z = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [29:0]        o_lobe_value;
    logic               o_below_horizon;

    blinn_phong_lobe_eval i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_x          (i_in_x),
        .i_in_y          (i_in_y),
        .i_in_z          (i_in_z),
        .i_out_x         (i_out_x),
        .i_out_y         (i_out_y),
        .i_out_z         (i_out_z),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_lobe_value    (o_lobe_value),
        .o_below_horizon (o_below_horizon)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // lobe predictor
    // ------------------------------------------------------------------
    logic [63:0] two_root[LOG_FRAC];   // 2^-(2^-(i+1)) in q0.32
    logic [24:0] shine_now;            // mirror of the shininess register

    function automatic logic [63:0] int_root(input logic [63:0] x);
        logic [63:0] rem, root, bit_w;
        rem   = x;
        root  = '0;
        bit_w = 64'd1 << 62;
        while (bit_w > rem) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (rem >= root + bit_w) begin
                rem  = rem - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    function automatic t_lobe_res lobe_predict(input logic signed [15:0] ix, iy, iz, ox, oy, oz,
                                               input logic [24:0] n);
        logic signed [17:0] hx, hy, hz;
        logic signed [63:0] wx, wy, wz;
        logic [63:0] len2, cos2, mant, frac, negl, expo, ipart, pw, amp, val;
        int          lead;
        t_lobe_res   r;
        hx = ix + ox;
        hy = iy + oy;
        hz = iz + oz;
        if (hz <= 0) begin
            r.lobe  = '0;
            r.below = 1'b1;
            return r;
        end
        wx   = hx;
        wy   = hy;
        wz   = hz;
        len2 = wx * wx + wy * wy + wz * wz;
        cos2 = ((wz * wz) << 32) / len2;
        if (cos2 == 0) begin
            // cosine squared lost to truncation
            pw = (n == 0) ? (64'd1 << 32) : 64'd0;
        end else begin
            // -log2(cos^2) in q.24 by repeated squaring
            lead = 0;
            while (lead < 63 && (cos2 >> (lead + 1)) != 0) lead++;
            mant = (lead >= 30) ? (cos2 >> (lead - 30)) : (cos2 << (30 - lead));
            frac = '0;
            for (int i = 1; i <= LOG_FRAC; i++) begin
                mant = (mant * mant) >> 30;
                if (mant >= (64'd1 << 31)) begin
                    frac = frac | (64'd1 << (LOG_FRAC - i));
                    mant = mant >> 1;
                end
            end
            negl  = (64'(32 - lead) << LOG_FRAC) - frac;
            expo  = (negl * 64'(n)) >> 9;
            ipart = expo >> LOG_FRAC;
            // 2^-expo: fraction bits via root table, then the integer shift
            pw = 64'd1 << 32;
            for (int i = 1; i <= LOG_FRAC; i++) begin
                if (expo[LOG_FRAC - i]) pw = (pw * two_root[i - 1]) >> 32;
            end
            pw = (ipart >= 33) ? 64'd0 : (pw >> ipart);
        end
        amp = (pw * (64'(n) + 64'd512)) >> 24;
        val = (amp >> 32) * 64'(INV_TWO_PI) + (((amp & 64'hFFFF_FFFF) * 64'(INV_TWO_PI)) >> 32);
        if (val > 64'(LOBE_MAX)) val = 64'(LOBE_MAX);
        r.lobe  = val[29:0];
        r.below = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // scoreboard
    // ------------------------------------------------------------------
    t_lobe_res  lobe_expected[$];
    int         n_mismatch = 0;
    int         n_results  = 0;
    int         n_below    = 0;
    int         n_sent     = 0;
    int         n_sat      = 0;
    t_idle_mode idle_mode  = IDLE_NONE;
    bit         hold_req   = 1'b0;
    bit         hold_done  = 1'b0;
    int         hold_left  = 0;
    int         cycle_cnt  = 0;

    always @(posedge i_clk) begin
        t_lobe_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (lobe_expected.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: lobe %0d below %0b",
                             o_lobe_value, o_below_horizon);
            end else begin
                want = lobe_expected.pop_front();
                if (want.below) n_below++;
                if (want.lobe == LOBE_MAX) n_sat++;
                if (o_lobe_value !== want.lobe || o_below_horizon !== want.below) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: lobe exp %0d got %0d, below exp %0b got %0b",
                                 want.lobe, o_lobe_value, want.below, o_below_horizon);
                end
            end
        end
    end

    // receiver: random stalls per idle profile, plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYC;
            hold_done <= 1'b1;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECV: i_out_ready <= ($urandom_range(0, 99) >= 77);
                IDLE_BOTH: i_out_ready <= ($urandom_range(0, 99) >= 20);
                default:   i_out_ready <= 1'b1;
            endcase
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, lobe_expected.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send_vec(input logic signed [15:0] ix, iy, iz, ox, oy, oz,
                            input bit typed, input t_lobe_res typed_res);
        int        gap_pct;
        t_lobe_res pred;
        t_lobe_res exp_res;
        gap_pct = (idle_mode == IDLE_SEND) ? 77 : (idle_mode == IDLE_BOTH) ? 20 : 0;
        // sender idle cycles before this transfer
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_x  <= ix;
        i_in_y  <= iy;
        i_in_z  <= iz;
        i_out_x <= ox;
        i_out_y <= oy;
        i_out_z <= oz;
        do @(posedge i_clk); while (!o_in_ready);
        pred = lobe_predict(ix, iy, iz, ox, oy, oz, shine_now);
        // typed rows must also agree with the predictor
        if (typed && typed_res !== pred) begin
            n_mismatch++;
            $display("typed row disagrees with predictor");
        end
        exp_res       = typed ? typed_res : pred;
        lobe_expected = {lobe_expected, exp_res};
        n_sent++;
    endtask

    task automatic drain_all();
        i_in_valid <= 1'b0;
        while (lobe_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_shine(input logic [24:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shine_now = v;
    endtask

    function automatic logic signed [15:0] rand_comp(input int lo, input int hi);
        return 16'($signed($urandom_range(hi - lo, 0)) + lo);
    endfunction

    t_stim_row dir_rows[$];

    task automatic add_row(input t_stim_row row);
        dir_rows = {dir_rows, row};
    endtask

    task automatic build_rows();
        t_lobe_res horizon;
        horizon = '{lobe: '0, below: 1'b1};
        // zero-length half vector
        add_row('{0, 0, 0, 0, 0, 0, 1, horizon});
        // both along the normal, full scale
        add_row('{0, 0, 32767, 0, 0, 32767, 0, horizon});
        // most negative z on both
        add_row('{0, 0, -32768, 0, 0, -32768, 1, horizon});
        // z cancels to exactly zero
        add_row('{0, 0, 32767, 0, 0, -32767, 1, horizon});
        add_row('{-32768, -32768, 32767, -32768, -32768, 32767, 0, horizon});
        // grazing half vector, cos^2 truncates to zero
        add_row('{32767, 32767, 1, 32767, 32767, 0, 0, horizon});
        add_row('{-32768, 32767, 1, -32768, 32767, 0, 0, horizon});
        add_row('{32767, -32768, 32767, -32768, 32767, 32767, 0, horizon});
        // smallest positive z, cosine one
        add_row('{0, 0, 1, 0, 0, 0, 0, horizon});
        add_row('{32767, 0, 0, 0, 0, 1, 0, horizon});
        add_row('{0, 32767, 23170, 0, -32768, 23170, 0, horizon});
        // all ones, negative z
        add_row('{-1, -1, -1, -1, -1, -1, 1, horizon});
        add_row('{16384, 0, 28378, -16384, 0, 28378, 0, horizon});
        add_row('{12000, -9000, 30000, 3000, 20000, 25000, 0, horizon});
        add_row('{32767, 32767, 32767, 32767, 32767, 32767, 0, horizon});
    endtask

    task automatic send_random();
        logic signed [15:0] v[6];
        case ($urandom_range(0, 3))
            0: begin    // anything, covers every bit and the below-horizon side
                foreach (v[i]) v[i] = 16'($urandom);
            end
            1: begin    // well above the horizon
                v[0] = 16'($urandom); v[1] = 16'($urandom); v[2] = rand_comp(8192, 32767);
                v[3] = 16'($urandom); v[4] = 16'($urandom); v[5] = rand_comp(8192, 32767);
            end
            2: begin    // close to the normal, sharp part of the lobe
                v[0] = rand_comp(-600, 600); v[1] = rand_comp(-600, 600);
                v[2] = rand_comp(20000, 32767);
                v[3] = rand_comp(-600, 600); v[4] = rand_comp(-600, 600);
                v[5] = rand_comp(20000, 32767);
            end
            default: begin  // grazing, tiny z that may also sum to zero or below
                v[0] = 16'($urandom); v[1] = 16'($urandom); v[2] = rand_comp(0, 40);
                v[3] = 16'($urandom); v[4] = 16'($urandom); v[5] = rand_comp(-20, 40);
            end
        endcase
        send_vec(v[0], v[1], v[2], v[3], v[4], v[5], 1'b0, '0);
    endtask

    logic [24:0] phase_shine[N_PHASES];

    initial begin
        two_root[0] = int_root(64'd1 << 63);
        for (int i = 1; i < LOG_FRAC; i++) two_root[i] = int_root(two_root[i - 1] << 32);
        shine_now = 25'd1280;
        build_rows();
        // reset value first, then zero, the top of the range, the nominal max, 1.0, random
        phase_shine = '{25'd1280, 25'd0, 25'h1FF_FFFF, 25'd25600000, 25'd256,
                        25'($urandom_range(0, 40000))};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            idle_mode = t_idle_mode'(ph % 4);
            if (ph != 0) begin
                drain_all();
                write_shine(phase_shine[ph]);
            end
            foreach (dir_rows[r])
                send_vec(dir_rows[r].ix, dir_rows[r].iy, dir_rows[r].iz,
                         dir_rows[r].ox, dir_rows[r].oy, dir_rows[r].oz,
                         dir_rows[r].typed, dir_rows[r].res);
            // long receiver hold-off while items keep coming, fills the pipe
            if (ph == 0) hold_req = 1'b1;
            for (int k = 0; k < RAND_ITEMS; k++) begin
                // sender waits for a full drain once, mid-phase
                if (ph == 2 && k == RAND_ITEMS / 2) begin
                    i_in_valid <= 1'b0;
                    while (lobe_expected.size() != 0) @(posedge i_clk);
                end
                send_random();
            end
        end

        drain_all();
        $display("covered %0d transfers over %0d shininess settings and four idle profiles",
                 n_sent, N_PHASES);
        $display("%0d results, %0d below horizon, %0d saturated, %0d mismatches",
                 n_results, n_below, n_sat, n_mismatch);
        if (n_mismatch == 0 && lobe_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
